@@ src/assert_macros.svh @@
// Assertion macros shared by the allocator RTL; each expects clk and rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define BFA_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define BFA_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/bfa_pkg.sv @@
// Shared types and constants of the best-fit block allocator.
`default_nettype none

package bfa_pkg;

  localparam int REQ_W = 13;
  localparam int OFS_W = 12;

  typedef struct packed {
    logic [REQ_W-1:0] request_size;
  } req_t;

  typedef struct packed {
    logic             granted;
    logic [OFS_W-1:0] payload_offset;
  } rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_WR_HEAD,
    ST_WR_TAIL,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

@@ src/bfa_chan_if.sv @@
// Valid/ready channel interface carrying one payload struct.
`default_nettype none

interface bfa_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

@@ src/bfa_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module bfa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ src/best_fit_block_allocator.sv @@
// Best-fit block allocator: walks the header chain held in one header RAM.
// A request walks the chain, then writes the chosen header and, on a split,
// the tail header, before its result is registered. A refused size, or a
// walk with no fit, goes straight to the result. A new request is accepted
// only after the previous result is registered, one request at a time.
// Reset (synchronous, active high) returns the pool to a single free block.
`default_nettype none
`include "assert_macros.svh"

module best_fit_block_allocator #(
  parameter int POOL_BYTES   = 4096,
  parameter int HEADER_BYTES = 16
) (
  input  wire logic clk,
  input  wire logic rst,
  bfa_chan_if.sink   req,
  bfa_chan_if.source rsp
);

  import bfa_pkg::*;

  // Address width covers every pool offset. A block size never reaches the
  // pool size, so sizes share that width. Chain positions get two extra bits
  // so that the step past the last header cannot wrap.
  localparam int AW   = $clog2(POOL_BYTES);
  localparam int SW   = AW;
  localparam int EW   = SW + 1;
  localparam int PW   = AW + 2;
  localparam int CW   = (PW > REQ_W) ? PW : REQ_W;
  localparam int SUMW = (PW > OFS_W) ? PW : OFS_W;

  // Each header RAM word is {allocated mark, block size}.
  state_t           state;
  state_t           state_next;
  logic [REQ_W-1:0] req_size;
  logic [AW-1:0]    pos;
  logic             found;
  logic [AW-1:0]    best_pos;
  logic [SW-1:0]    best_size;
  logic [SW-1:0]    best_left;
  logic             grant_q;
  logic             hdr0_written;
  logic             out_valid;
  rsp_t             out_payload;

  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [EW-1:0]    ram_wdata;
  logic [AW-1:0]    ram_raddr;
  logic [EW-1:0]    ram_rdata;

  logic [EW-1:0]    ent;
  logic             ent_used;
  logic [SW-1:0]    ent_size;
  logic [SW-1:0]    req_sw;
  logic [SW-1:0]    left;
  logic             fits;
  logic             better;
  logic [PW-1:0]    next_pos;
  logic             walk_more;
  logic             req_ok;
  logic             split;
  logic [PW-1:0]    tail_sum;
  logic             tail_in;
  logic [SUMW-1:0]  ofs_sum;
  logic             accept;
  logic             out_load;

  bfa_ram #(
    .WIDTH (EW),
    .DEPTH (POOL_BYTES)
  ) u_hdr_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // The RAM holds no reset contents. Every header on the chain except the one
  // at offset zero is written as a split tail before the walk can reach it,
  // so only offset zero needs a reset value: it reads as the pool-wide free
  // block until its first write.
  assign ent      = (pos == '0 && !hdr0_written) ?
                    {1'b0, SW'(POOL_BYTES - HEADER_BYTES)} : ram_rdata;
  assign ent_used = ent[SW];
  assign ent_size = ent[SW-1:0];

  // A fitting request never exceeds the block size, so the truncation to the
  // size width is exact wherever it matters.
  assign req_sw   = req_size[SW-1:0];
  assign fits     = !ent_used && (CW'(ent_size) >= CW'(req_size));
  assign left     = ent_size - req_sw;
  assign better   = fits && (!found || left < best_left);

  // The next header follows the payload of the current one.
  assign next_pos  = PW'(pos) + PW'(HEADER_BYTES) + PW'(ent_size);
  assign walk_more = next_pos < PW'(POOL_BYTES);

  assign req_ok = (req.payload.request_size != '0) &&
                  (CW'(req.payload.request_size) <= CW'(POOL_BYTES));

  // Split when the leftover can hold a header; the tail header then sits
  // right behind the shortened payload.
  assign split    = CW'(best_left) >= CW'(HEADER_BYTES);
  assign tail_sum = PW'(best_pos) + PW'(HEADER_BYTES) + PW'(req_sw);
  assign tail_in  = tail_sum < PW'(POOL_BYTES);

  assign ofs_sum  = SUMW'(best_pos) + SUMW'(HEADER_BYTES);

  assign accept   = req.valid && req.ready;
  assign out_load = (state == ST_DONE) && (!out_valid || rsp.ready);

  assign req.ready   = (state == ST_IDLE);
  assign rsp.valid   = out_valid;
  assign rsp.payload = out_payload;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state, and the RAM port controls. The read address is issued in the
  // same cycle that the previous header's word arrives, so the walk moves one
  // header per cycle.
  always_comb begin
    state_next = state;
    ram_we     = 1'b0;
    ram_waddr  = best_pos;
    ram_wdata  = {1'b1, best_size};
    ram_raddr  = '0;
    unique case (state)
      ST_IDLE: begin
        if (req.valid) begin
          state_next = req_ok ? ST_WALK : ST_DONE;
        end
      end
      ST_WALK: begin
        ram_raddr = next_pos[AW-1:0];
        if (!walk_more) begin
          state_next = (found || better) ? ST_WR_HEAD : ST_DONE;
        end
      end
      ST_WR_HEAD: begin
        ram_we     = 1'b1;
        ram_waddr  = best_pos;
        ram_wdata  = {1'b1, split ? req_sw : best_size};
        state_next = (split && tail_in) ? ST_WR_TAIL : ST_DONE;
      end
      ST_WR_TAIL: begin
        ram_we     = 1'b1;
        ram_waddr  = tail_sum[AW-1:0];
        ram_wdata  = {1'b0, best_left - SW'(HEADER_BYTES)};
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid || rsp.ready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control state: result valid flag and the offset-zero write mark.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid    <= 1'b0;
      hdr0_written <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      if (ram_we && ram_waddr == '0) begin
        hdr0_written <= 1'b1;
      end
    end
  end

  // Walk bookkeeping. On equal leftovers the first block in chain order wins,
  // since only a strictly smaller leftover replaces the current best.
  always_ff @(posedge clk) begin
    if (accept) begin
      req_size <= req.payload.request_size;
      pos      <= '0;
      found    <= 1'b0;
      grant_q  <= 1'b0;
    end
    if (state == ST_WALK) begin
      if (better) begin
        found     <= 1'b1;
        best_pos  <= pos;
        best_size <= ent_size;
        best_left <= left;
      end
      if (walk_more) begin
        pos <= next_pos[AW-1:0];
      end
    end
    if (state == ST_WR_HEAD) begin
      grant_q <= 1'b1;
    end
    if (out_load) begin
      out_payload.granted        <= grant_q;
      out_payload.payload_offset <= grant_q ? ofs_sum[OFS_W-1:0] : '0;
    end
  end

  `BFA_ASSERT_NXT(a_accept_leaves_idle, accept, state != ST_IDLE, "request accepted but FSM idle")
  `BFA_ASSERT_IMP(a_walk_pos_in_pool, state == ST_WALK, PW'(pos) < PW'(POOL_BYTES), "walk left pool")
  `BFA_ASSERT_IMP(a_head_write_found, state == ST_WR_HEAD, found, "header write without a fit")
  `BFA_ASSERT_IMP(a_tail_after_head, state == ST_WR_TAIL, tail_sum > PW'(best_pos), "tail before head")
  `BFA_ASSERT_IMP(a_grant_has_fit, state == ST_DONE && grant_q, found, "grant without a fit")

endmodule

`default_nettype wire
